### hdl/twcar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twcar_pkg;

    // cache geometry
    localparam int NUM_SETS = 48;
    localparam int NUM_WAYS = 2;
    localparam int AGE_BITS = 4;

    localparam int BLOCK_W   = 58;
    localparam int LINE_IDX_W = 7;
    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int IDX_CALC_W = 16;

    // func codes
    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_PROBE  = 1'b1;

    // set reduction: block number split into chunks, each chunk's residue from a table
    localparam int CHUNK_BITS  = 6;
    localparam int CHUNK_VALS  = 1 << CHUNK_BITS;
    localparam int NUM_CHUNKS  = (BLOCK_W + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PAD_W       = NUM_CHUNKS * CHUNK_BITS;
    localparam int SUM_W       = $clog2(NUM_CHUNKS * NUM_SETS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SET,
        S_UPD
    } t_state;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [AGE_BITS-1:0] age;
        logic [BLOCK_W-1:0]  tag;
    } t_line;

    typedef t_line [NUM_WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    typedef logic [NUM_CHUNKS-1:0][CHUNK_VALS-1:0][SET_W-1:0] t_res_tab;

    // residue of (chunk value << chunk position) modulo the set count
    function automatic t_res_tab build_res_tab();
        t_res_tab          tab;
        longint unsigned   pw;
        longint unsigned   prod;
        int                j;
        int                c;
        tab = '0;
        pw  = 64'd1 % NUM_SETS;
        for (j = 0; j < NUM_CHUNKS; j++) begin
            for (c = 0; c < CHUNK_VALS; c++) begin
                prod      = (longint'(c) * pw) % NUM_SETS;
                tab[j][c] = prod[SET_W-1:0];
            end
            pw = (pw << CHUNK_BITS) % NUM_SETS;
        end
        return tab;
    endfunction

    localparam t_res_tab RES_TAB = build_res_tab();

endpackage

`default_nettype wire

### hdl/twcar_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module twcar_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/two_way_cache_age_replacement.sv
`timescale 1ns / 1ps
`default_nettype none

// metadata controller of a set-associative block cache with age-counter replacement
//
// command channel: an item (func, block number, modify) is taken at a rising edge
// where start is high and busy is low. func 0 is an access that looks up,
// replaces and ages the set; func 1 is a probe that only reports the hit
// result channel: o_valid is high for exactly one cycle with hit, line_index,
// fill_needed, writeback_needed and victim_block; the receiver cannot hold it off
// an accepted item passes the set state and then the update state, from which
// the result strobe is registered; the set row is read-modify-written in the
// single metadata ram (read issued in the set state, written in the update state);
// busy is high only in the read cycle, so the next item is taken at the same
// edge that writes back the previous one and its read then sees the new row
// the set index comes from a table of chunk residues summed in the accept cycle
// and reduced by a compare-and-subtract in the read cycle
// reset: the state machine goes idle and the per-set row flags clear, so every
// line reads invalid at once; no clearing pass over the ram is needed

module two_way_cache_age_replacement
    import twcar_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_func,
    input  wire logic [BLOCK_W-1:0] i_blk_no,
    input  wire logic               i_modify,
    output logic                    o_valid,
    output logic                    o_hit,
    output logic [LINE_IDX_W-1:0]   o_line_index,
    output logic                    o_fill_needed,
    output logic                    o_writeback_needed,
    output logic [BLOCK_W-1:0]      o_victim_block
);

    t_state r_state, n_state;

    // item registers
    logic               r_func;
    logic               r_modify;
    logic [BLOCK_W-1:0] r_blk;
    logic [SUM_W-1:0]   r_sum;
    logic [SET_W-1:0]   r_set;

    // per-set row flags, a cleared flag means all lines of the set are invalid
    logic [NUM_SETS-1:0] r_row_valid;

    // result registers
    logic                  r_valid;
    logic                  r_hit;
    logic [LINE_IDX_W-1:0] r_line_index;
    logic                  r_fill;
    logic                  r_wb;
    logic [BLOCK_W-1:0]    r_victim;

    logic accept;
    logic is_access;
    logic ram_we;
    logic n_valid;

    logic [PAD_W-1:0] blk_pad;
    logic [SUM_W-1:0] sum_in;
    logic [SUM_W-1:0] sum_sub;
    logic [SET_W-1:0] set_idx;

    logic [ROW_W-1:0] ram_rdata;
    t_row             row_rd;
    t_row             row_wr;

    logic                hit;
    logic [WAY_W-1:0]    hit_way;
    logic                found_inv;
    logic [AGE_BITS-1:0] best;
    logic [AGE_BITS-1:0] cand;
    logic [WAY_W-1:0]    vic_way;
    logic [WAY_W-1:0]    way;
    logic                wb;
    logic [BLOCK_W-1:0]  victim;
    logic [IDX_CALC_W-1:0] idx_full;

    assign accept    = start && !busy;
    assign is_access = (r_func == FUNC_ACCESS);

    // ---------------- control ----------------

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SET;
                end
            end
            S_SET: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                // a new item can enter while this one writes back
                n_state = start ? S_SET : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy    = 1'b0;
        ram_we  = 1'b0;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_SET: begin
                busy = 1'b1;
            end
            S_UPD: begin
                ram_we  = is_access;
                n_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ---------------- set index ----------------

    // residues of each 6-bit chunk, summed in the accept cycle
    always_comb begin
        blk_pad = PAD_W'(i_blk_no);
        sum_in  = '0;
        for (int j = 0; j < NUM_CHUNKS; j++) begin
            sum_in = sum_in + SUM_W'(RES_TAB[j][blk_pad[j*CHUNK_BITS +: CHUNK_BITS]]);
        end
    end

    // sum is below NUM_CHUNKS sets, take off the largest multiple that fits
    always_comb begin
        sum_sub = '0;
        for (int k = 1; k < NUM_CHUNKS; k++) begin
            if (r_sum >= SUM_W'(k * NUM_SETS)) begin
                sum_sub = SUM_W'(k * NUM_SETS);
            end
        end
        set_idx = SET_W'(r_sum - sum_sub);
    end

    // ---------------- metadata ram ----------------

    twcar_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_set),
        .i_wdata (row_wr),
        .i_raddr (set_idx),
        .o_rdata (ram_rdata)
    );

    assign row_rd = r_row_valid[r_set] ? t_row'(ram_rdata) : '0;

    // ---------------- lookup and replacement ----------------

    always_comb begin
        // hit search, lowest way first
        hit     = 1'b0;
        hit_way = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (!hit && row_rd[i].valid && row_rd[i].tag == r_blk) begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
        end

        // first invalid way, else the largest wrapped age+1, way 0 by default
        found_inv = 1'b0;
        best      = '0;
        cand      = '0;
        vic_way   = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (!found_inv) begin
                if (!row_rd[i].valid) begin
                    vic_way   = WAY_W'(i);
                    found_inv = 1'b1;
                end else begin
                    cand = row_rd[i].age + 1'b1;
                    if (cand > best) begin
                        best    = cand;
                        vic_way = WAY_W'(i);
                    end
                end
            end
        end

        if (hit) begin
            way = hit_way;
        end else if (r_func == FUNC_PROBE) begin
            way = '0;
        end else begin
            way = vic_way;
        end

        // updated row: other valid ways age, the chosen line refreshes
        row_wr = row_rd;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (WAY_W'(i) != way && row_rd[i].valid && row_rd[i].tag != r_blk) begin
                row_wr[i].age = row_rd[i].age + 1'b1;
            end
        end

        wb     = 1'b0;
        victim = '0;
        if (hit) begin
            row_wr[way].age   = '0;
            row_wr[way].dirty = row_rd[way].dirty || r_modify;
        end else begin
            if (row_rd[way].valid && row_rd[way].dirty) begin
                wb     = 1'b1;
                victim = row_rd[way].tag;
            end
            row_wr[way].valid = 1'b1;
            row_wr[way].dirty = r_modify;
            row_wr[way].age   = '0;
            row_wr[way].tag   = r_blk;
        end

        idx_full = IDX_CALC_W'(r_set) * IDX_CALC_W'(NUM_WAYS) + IDX_CALC_W'(way);
    end

    // ---------------- registers ----------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_valid <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (ram_we) begin
                r_row_valid[r_set] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_func;
            r_modify <= i_modify;
            r_blk    <= i_blk_no;
            r_sum    <= sum_in;
        end
        if (r_state == S_SET) begin
            r_set <= set_idx;
        end
        if (n_valid) begin
            r_hit        <= hit;
            r_line_index <= idx_full[LINE_IDX_W-1:0];
            r_fill       <= is_access && !hit;
            r_wb         <= is_access && !hit && wb;
            r_victim     <= (is_access && !hit) ? victim : '0;
        end
    end

    assign o_valid            = r_valid;
    assign o_hit              = r_hit;
    assign o_line_index       = r_line_index;
    assign o_fill_needed      = r_fill;
    assign o_writeback_needed = r_wb;
    assign o_victim_block     = r_victim;

endmodule

`default_nettype wire

### sim/two_way_cache_age_replacement_test.sv
`timescale 1ns / 1ps

module two_way_cache_age_replacement_test;
    import twcar_pkg::*;

    localparam int LINES         = NUM_SETS * NUM_WAYS;
    localparam int RANDOM_ITEMS  = 600;
    localparam int POOL_SETS     = 3;
    localparam int TAGS_PER_SET  = 4;
    localparam logic [BLOCK_W-1:0] ADDR_MAX = '1;

    // one predicted lookup outcome, field for field as on the result ports
    typedef struct {
        logic                  hit;
        logic [LINE_IDX_W-1:0] line_index;
        logic                  fill_needed;
        logic                  writeback_needed;
        logic [BLOCK_W-1:0]    victim_block;
    } t_lookup_outcome;

    // mirror of the cache tags and ages plus the queue of outcomes still due
    class cache_tag_scoreboard;
        bit                  line_valid [LINES];
        bit                  line_dirty [LINES];
        logic [AGE_BITS-1:0] line_age   [LINES];
        logic [BLOCK_W-1:0]  line_tag   [LINES];
        t_lookup_outcome     due_outcomes[$];
        int mismatches;
        int n_items, n_probes, n_hits, n_fills, n_writebacks, n_results;

        function new();
            for (int i = 0; i < LINES; i++) begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_age[i]   = '0;
                line_tag[i]   = '0;
            end
            mismatches = 0;
            n_items = 0; n_probes = 0; n_hits = 0;
            n_fills = 0; n_writebacks = 0; n_results = 0;
        endfunction

        // predict the outcome of an accepted item and update the mirrored lines
        function void note_item(bit func, logic [BLOCK_W-1:0] addr, bit modify);
            int unsigned         set_no;
            int unsigned         base;
            int unsigned         way;
            bit                  hit;
            bit                  found;
            logic [AGE_BITS-1:0] best;
            logic [AGE_BITS-1:0] bumped;
            t_lookup_outcome     res;
            set_no = addr % NUM_SETS;
            base   = set_no * NUM_WAYS;
            way    = 0;
            hit    = 1'b0;
            res.fill_needed      = 1'b0;
            res.writeback_needed = 1'b0;
            res.victim_block     = '0;

            // the hit search covers every way before any replacement choice
            for (int i = 0; i < NUM_WAYS; i++) begin
                if (!hit && line_valid[base+i] && line_tag[base+i] == addr) begin
                    hit = 1'b1;
                    way = i;
                end
            end

            if (func == FUNC_ACCESS) begin
                if (!hit) begin
                    // first invalid way wins, else largest wrapped age+1, way 0 default
                    best  = '0;
                    found = 1'b0;
                    for (int i = 0; i < NUM_WAYS; i++) begin
                        if (!found) begin
                            if (!line_valid[base+i]) begin
                                way   = i;
                                found = 1'b1;
                            end else begin
                                bumped = line_age[base+i] + 1'b1;
                                if (bumped > best) begin
                                    best = bumped;
                                    way  = i;
                                end
                            end
                        end
                    end
                end
                for (int i = 0; i < NUM_WAYS; i++) begin
                    if (i != way && line_valid[base+i] && line_tag[base+i] != addr)
                        line_age[base+i] = line_age[base+i] + 1'b1;
                end
                if (hit) begin
                    line_age[base+way] = '0;
                    if (modify)
                        line_dirty[base+way] = 1'b1;
                end else begin
                    if (line_valid[base+way] && line_dirty[base+way]) begin
                        res.writeback_needed = 1'b1;
                        res.victim_block     = line_tag[base+way];
                        n_writebacks++;
                    end
                    res.fill_needed      = 1'b1;
                    line_valid[base+way] = 1'b1;
                    line_dirty[base+way] = modify;
                    line_age[base+way]   = '0;
                    line_tag[base+way]   = addr;
                    n_fills++;
                end
            end else begin
                n_probes++;
            end

            if (hit)
                n_hits++;
            n_items++;
            res.hit        = hit;
            res.line_index = LINE_IDX_W'(base + way);
            due_outcomes.push_back(res);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(logic hit, logic [LINE_IDX_W-1:0] line_index, logic fill,
                          logic wb, logic [BLOCK_W-1:0] victim);
            t_lookup_outcome want;
            n_results++;
            if (due_outcomes.size() == 0) begin
                report_mismatch("result with no item pending", 64'(line_index), 64'd0);
            end else begin
                want = due_outcomes.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", 64'(hit), 64'(want.hit));
                if (line_index !== want.line_index)
                    report_mismatch("line_index", 64'(line_index), 64'(want.line_index));
                if (fill !== want.fill_needed)
                    report_mismatch("fill_needed", 64'(fill), 64'(want.fill_needed));
                if (wb !== want.writeback_needed)
                    report_mismatch("writeback_needed", 64'(wb), 64'(want.writeback_needed));
                if (victim !== want.victim_block)
                    report_mismatch("victim_block", 64'(victim), 64'(want.victim_block));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_func;
    logic [BLOCK_W-1:0] i_blk_no;
    logic               i_modify;
    logic                  o_valid;
    logic                  o_hit;
    logic [LINE_IDX_W-1:0] o_line_index;
    logic                  o_fill_needed;
    logic                  o_writeback_needed;
    logic [BLOCK_W-1:0]    o_victim_block;

    cache_tag_scoreboard sb = new();

    // sender burst bookkeeping
    int burst_left = 1;
    // addresses crowded into a few sets so that hits, aging and evictions happen
    logic [BLOCK_W-1:0] addr_pool [POOL_SETS*TAGS_PER_SET];

    two_way_cache_age_replacement dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_func             (i_func),
        .i_blk_no           (i_blk_no),
        .i_modify           (i_modify),
        .o_valid            (o_valid),
        .o_hit              (o_hit),
        .o_line_index       (o_line_index),
        .o_fill_needed      (o_fill_needed),
        .o_writeback_needed (o_writeback_needed),
        .o_victim_block     (o_victim_block)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // results are strobed for one cycle; sample them at the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0)
            sb.check_result(o_hit, o_line_index, o_fill_needed, o_writeback_needed,
                            o_victim_block);
    end

    // a random block number that falls into the given set
    function automatic logic [BLOCK_W-1:0] addr_in_set(int unsigned set_no);
        logic [BLOCK_W-1:0] a;
        a = BLOCK_W'({$urandom, $urandom});
        // keep room at the top so adding the set number cannot wrap
        if (a > ADDR_MAX - BLOCK_W'(64))
            a = a - BLOCK_W'(64);
        return a - (a % NUM_SETS) + BLOCK_W'(set_no);
    endfunction

    task automatic refresh_pool();
        int unsigned set_no;
        for (int s = 0; s < POOL_SETS; s++) begin
            set_no = $urandom_range(0, NUM_SETS - 1);
            for (int t = 0; t < TAGS_PER_SET; t++)
                addr_pool[s*TAGS_PER_SET + t] = addr_in_set(set_no);
        end
    endtask

    // present one item, hold it until taken, then maybe pause between bursts
    task automatic issue_item(bit func, logic [BLOCK_W-1:0] addr, bit modify);
        int gap;
        i_func   <= func;
        i_blk_no <= addr;
        i_modify <= modify;
        start    <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        sb.note_item(func, addr, modify);
        burst_left--;
        if (burst_left <= 0) begin
            // about a quarter of the bursts run straight into the next one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        int          pick;
        int unsigned slot;
        logic [BLOCK_W-1:0] addr;
        bit          func;

        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_func   <= FUNC_ACCESS;
        i_blk_no <= '0;
        i_modify <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty probe, fills, hits with and without modify
        issue_item(FUNC_PROBE,  '0, 1'b0);
        issue_item(FUNC_ACCESS, '0, 1'b1);
        issue_item(FUNC_ACCESS, BLOCK_W'(48), 1'b0);
        issue_item(FUNC_PROBE,  BLOCK_W'(48), 1'b1);
        // fourteen hits on way 1 push the age of way 0 to its top value
        for (int k = 0; k < 14; k++)
            issue_item(FUNC_ACCESS, BLOCK_W'(48), bit'(k % 2));
        // way 0 wraps to the lowest rank, so dirty way 1 is replaced
        issue_item(FUNC_ACCESS, BLOCK_W'(96), 1'b0);
        issue_item(FUNC_PROBE,  BLOCK_W'(48), 1'b0);
        // top of the block number range, evicted dirty as an all-ones victim
        issue_item(FUNC_ACCESS, ADDR_MAX, 1'b1);
        issue_item(FUNC_PROBE,  ADDR_MAX, 1'b0);
        issue_item(FUNC_ACCESS, ADDR_MAX - BLOCK_W'(48), 1'b0);
        issue_item(FUNC_ACCESS, ADDR_MAX - BLOCK_W'(96), 1'b0);

        // random: mostly crowded sets with a favored tag, some fully random addresses
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                refresh_pool();
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, POOL_SETS - 1);
            if (pick < 15)
                addr = BLOCK_W'({$urandom, $urandom});
            else if (pick < 50)
                addr = addr_pool[slot*TAGS_PER_SET];
            else
                addr = addr_pool[$urandom_range(0, POOL_SETS*TAGS_PER_SET - 1)];
            func = ($urandom_range(0, 3) == 0) ? FUNC_PROBE : FUNC_ACCESS;
            issue_item(func, addr, bit'($urandom_range(0, 1)));
        end
        start <= 1'b0;

        // drain, then keep the clock running for any stray strobe
        while (sb.due_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d items (%0d probes): %0d hits, %0d fills, %0d write-backs",
                 sb.n_items, sb.n_probes, sb.n_hits, sb.n_fills, sb.n_writebacks);
        $display("%0d results checked, %0d mismatches", sb.n_results, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d results still due", sb.due_outcomes.size());
        $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
hdl/twcar_pkg.sv
hdl/twcar_ram.sv
hdl/two_way_cache_age_replacement.sv
sim/two_way_cache_age_replacement_test.sv
